@@ hdl/dlp_pkg.sv @@
// ----------------------------------------------------------------------------
// Delimited record parser package
// Shared item types, character codes and token bookkeeping helpers.
// ----------------------------------------------------------------------------
package dlp_pkg;

  // Class of one queued item, as decided by the front end.
  typedef enum logic [1:0] {
    KIND_SPACE = 2'd0,
    KIND_DIGIT = 2'd1,
    KIND_OTHER = 2'd2,
    KIND_EOL   = 2'd3
  } kind_e;

  // One classified item travelling through the queue.
  typedef struct packed {
    kind_e      kind;
    logic [3:0] digit;
  } item_t;

  // Store slot that a token number maps to.
  typedef struct packed {
    logic       valid;
    logic [2:0] idx;
  } slot_t;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [3:0] TOKEN_SAT    = 4'd11;
  localparam logic [3:0] TOKEN_OFFSET = 4'd6;
  localparam logic [3:0] TOKEN_MIN    = 4'd7;
  localparam logic [3:0] TOKEN_SAMPLE = 4'd8;
  localparam logic [3:0] TOKEN_FULL   = 4'd10;

  localparam int unsigned NumSlots   = 8;
  localparam logic [2:0]  SLOT_OFFSET = 3'd4;

  // Tokens two to seven land in slots zero to five, tokens nine and ten in
  // slots six and seven; every other token is skipped.
  function automatic slot_t slot_of(logic [3:0] tok);
    slot_t s;
    s.valid = 1'b0;
    s.idx   = 3'd0;
    case (tok) inside
      [4'd2:4'd7]: begin
        s.valid = 1'b1;
        s.idx   = 3'(tok - 4'd2);
      end
      4'd9: begin
        s.valid = 1'b1;
        s.idx   = 3'd6;
      end
      4'd10: begin
        s.valid = 1'b1;
        s.idx   = 3'd7;
      end
      default: begin
        s.valid = 1'b0;
        s.idx   = 3'd0;
      end
    endcase
    return s;
  endfunction

endpackage

@@ hdl/dlp_front.sv @@
// ----------------------------------------------------------------------------
// Delimited record parser front end
// Accepts input transfers and classifies each byte before queueing it.
// ----------------------------------------------------------------------------
module dlp_front (
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    ch_i,
  input  logic          end_of_line_i,
  input  logic          q_full_i,
  output logic          push_o,
  output dlp_pkg::item_t item_o
);
  import dlp_pkg::*;

  // A transfer is taken whenever the queue has room.
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

  // Classify the byte into separator, digit or other token byte, or mark an end of line.
  always_comb begin
    item_o.digit = ch_i[3:0];
    if (end_of_line_i) begin
      item_o.kind = KIND_EOL;
    end else begin
      case (ch_i) inside
        CHAR_SPACE, CHAR_TAB:     item_o.kind = KIND_SPACE;
        [CHAR_ZERO:CHAR_NINE]:    item_o.kind = KIND_DIGIT;
        default:                  item_o.kind = KIND_OTHER;
      endcase
    end
  end

endmodule

@@ hdl/dlp_fifo.sv @@
// ----------------------------------------------------------------------------
// Delimited record parser item queue
// Short register queue that decouples the front end from the parser.
// ----------------------------------------------------------------------------
module dlp_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dlp_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output dlp_pkg::item_t item_o
);
  import dlp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntFull);
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull) else $error("queue count beyond depth");

  // Nothing is popped from an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");

  // A lone push into a queue with room leaves it non-empty.
  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i && !full_o) |=> !empty_o) else $error("push lost");

endmodule

@@ hdl/dlp_back.sv @@
// ----------------------------------------------------------------------------
// Delimited record parser back end
// Tracks tokens, accumulates decimal values and registers one result per line.
// ----------------------------------------------------------------------------
module dlp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  dlp_pkg::item_t item_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           ok_o,
  output logic [31:0]    index_value_o,
  output logic [31:0]    total_value_o,
  output logic [31:0]    countable_value_o,
  output logic [31:0]    molecules_value_o,
  output logic [63:0]    offset_value_o,
  output logic [31:0]    data_bytes_value_o,
  output logic           has_sample_o,
  output logic [31:0]    hex_value_o,
  output logic [31:0]    poly_value_o
);
  import dlp_pkg::*;

  // Per-line state.
  logic [3:0]  tok_q;
  logic        in_token_q;
  logic        line_bytes_q;
  logic        line_err_q;
  logic [63:0] acc_q;
  logic [31:0] store_q [NumSlots];
  logic [31:0] offset_hi_q;

  // Output register.
  logic        out_valid_q;
  logic        ok_q, sample_q;
  logic [31:0] val_q [NumSlots];
  logic [31:0] off_hi_q;

  logic        room;
  logic        is_eol;
  logic [3:0]  tok_new;
  logic [63:0] acc_base;
  logic [67:0] acc_ext, prod;
  logic        ovf;
  slot_t       slot_cur, slot_new;
  logic        fin;
  logic [31:0] val_d [NumSlots];
  logic [31:0] off_hi_d;
  logic        ok_d, sample_d;

  // An end of line only moves on once the output register can take it.
  assign room   = ~out_valid_q | ~out_stall_i;
  assign is_eol = (item_i.kind == KIND_EOL);
  assign pop_o  = ~empty_i & (~is_eol | room);

  // Token that a non-separator byte belongs to.
  assign tok_new  = in_token_q ? tok_q : ((tok_q < TOKEN_SAT) ? tok_q + 4'd1 : tok_q);
  assign acc_base = in_token_q ? acc_q : '0;
  assign slot_cur = slot_of(tok_q);
  assign slot_new = slot_of(tok_new);
  assign fin      = in_token_q & slot_cur.valid;

  // Multiply by ten as two shifts and one add, then check the token width.
  // Ten times a full 64-bit value needs 68 bits to stay exact.
  assign acc_ext = {4'b0000, acc_base};
  assign prod    = (acc_ext << 3) + (acc_ext << 1) + {64'd0, item_i.digit};
  assign ovf     = (tok_new == TOKEN_OFFSET) ? (|prod[67:64]) : (|prod[67:32]);

  // Field values as they stand once the open token is closed.
  always_comb begin
    for (int k = 0; k < NumSlots; k++) begin
      val_d[k] = (fin && slot_cur.idx == 3'(k)) ? acc_q[31:0] : store_q[k];
    end
    off_hi_d = (fin && slot_cur.idx == SLOT_OFFSET) ? acc_q[63:32] : offset_hi_q;
    sample_d = (tok_q >= TOKEN_SAMPLE);
    ok_d     = ~line_err_q & (tok_q >= TOKEN_MIN) &
               ((tok_q == TOKEN_MIN) | (tok_q >= TOKEN_FULL));
  end

  // Line control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q        <= '0;
      in_token_q   <= 1'b0;
      line_bytes_q <= 1'b0;
      line_err_q   <= 1'b0;
      acc_q        <= '0;
    end else if (pop_o) begin
      case (item_i.kind)
        KIND_SPACE: begin
          line_bytes_q <= 1'b1;
          in_token_q   <= 1'b0;
        end
        KIND_DIGIT, KIND_OTHER: begin
          line_bytes_q <= 1'b1;
          in_token_q   <= 1'b1;
          tok_q        <= tok_new;
          if (!in_token_q) begin
            acc_q <= '0;
          end
          if (slot_new.valid) begin
            if (item_i.kind == KIND_OTHER || ovf) begin
              line_err_q <= 1'b1;
            end else begin
              acc_q <= prod[63:0];
            end
          end
        end
        default: begin
          tok_q        <= '0;
          in_token_q   <= 1'b0;
          line_bytes_q <= 1'b0;
          line_err_q   <= 1'b0;
          acc_q        <= '0;
        end
      endcase
    end
  end

  // Field store, written when a numeric token closes on a separator.
  always_ff @(posedge clk_i) begin
    if (pop_o && item_i.kind == KIND_SPACE && fin) begin
      store_q[slot_cur.idx] <= acc_q[31:0];
      if (slot_cur.idx == SLOT_OFFSET) begin
        offset_hi_q <= acc_q[63:32];
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && is_eol && line_bytes_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload; a failed line reports all zeros.
  always_ff @(posedge clk_i) begin
    if (pop_o && is_eol && line_bytes_q) begin
      ok_q     <= ok_d;
      sample_q <= ok_d & sample_d;
      off_hi_q <= ok_d ? off_hi_d : '0;
      for (int k = 0; k < NumSlots; k++) begin
        if (k >= 6) begin
          val_q[k] <= (ok_d && sample_d) ? val_d[k] : '0;
        end else begin
          val_q[k] <= ok_d ? val_d[k] : '0;
        end
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign ok_o               = ok_q;
  assign index_value_o      = val_q[0];
  assign total_value_o      = val_q[1];
  assign countable_value_o  = val_q[2];
  assign molecules_value_o  = val_q[3];
  assign offset_value_o     = {off_hi_q, val_q[4]};
  assign data_bytes_value_o = val_q[5];
  assign has_sample_o       = sample_q;
  assign hex_value_o        = val_q[6];
  assign poly_value_o       = val_q[7];

  // The token count saturates and never runs past its limit.
  a_tok_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_q <= TOKEN_SAT) else $error("token count past saturation");

  // A non-empty line that ends always yields a result.
  a_line_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && is_eol && line_bytes_q) |=> out_valid_q)
    else $error("line result dropped");

  // A failed line carries zero fields.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !ok_q) |-> (!sample_q && val_q[0] == '0 && off_hi_q == '0 &&
                                val_q[4] == '0 && val_q[7] == '0))
    else $error("failed line with nonzero fields");

  // Without the optional group the last two fields read zero.
  a_no_sample_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !sample_q) |-> (val_q[6] == '0 && val_q[7] == '0))
    else $error("optional fields set without sample");

endmodule

@@ hdl/delimited_record_field_parser_core.sv @@
// ----------------------------------------------------------------------------
// Delimited record field parser core
// Parses whitespace-separated decimal fields of a text line into one record.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one line byte per transfer (ch_i), followed by
//   a transfer with end_of_line_i set that closes the line. A transfer
//   happens when in_valid_i is high and in_stall_o is low.
//   Each non-empty line yields one result transfer on the output channel
//   (out_valid_o high, out_stall_i low) with ok_o and the field values.
//   Lines that end with no bytes produce nothing.
//   Throughput is one input transfer per cycle while in_stall_o is low;
//   every digit byte of a stored field costs one pass through the
//   multiply-by-ten accumulate in the parser. The end-of-line transfer
//   passes through the item queue and then into the output register.
//   While the receiver stalls, the result holds and the parser keeps taking
//   bytes of the next line; only its end of line waits. The queue of Depth
//   items then fills and in_stall_o rises.
//   Reset clears the queue, the line state and the output valid flag; the
//   block accepts transfers as soon as reset is released.
// ----------------------------------------------------------------------------
module delimited_record_field_parser_core #(
  parameter int unsigned Depth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  input  logic        end_of_line_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        ok_o,
  output logic [31:0] index_value_o,
  output logic [31:0] total_value_o,
  output logic [31:0] countable_value_o,
  output logic [31:0] molecules_value_o,
  output logic [63:0] offset_value_o,
  output logic [31:0] data_bytes_value_o,
  output logic        has_sample_o,
  output logic [31:0] hex_value_o,
  output logic [31:0] poly_value_o
);
  import dlp_pkg::*;

  logic  push, pop, q_full, q_empty;
  item_t push_item, head_item;

  // Front end: transfer acceptance and byte classification.
  dlp_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .ch_i          (ch_i),
    .end_of_line_i (end_of_line_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .item_o        (push_item)
  );

  // Queue between the front end and the parser.
  dlp_fifo #(
    .Depth (Depth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .item_o  (head_item)
  );

  // Back end: token parsing and result register.
  dlp_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .empty_i            (q_empty),
    .item_i             (head_item),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .ok_o               (ok_o),
    .index_value_o      (index_value_o),
    .total_value_o      (total_value_o),
    .countable_value_o  (countable_value_o),
    .molecules_value_o  (molecules_value_o),
    .offset_value_o     (offset_value_o),
    .data_bytes_value_o (data_bytes_value_o),
    .has_sample_o       (has_sample_o),
    .hex_value_o        (hex_value_o),
    .poly_value_o       (poly_value_o)
  );

endmodule
